FILE: hw/rtl/rsw_pkg.sv
// ----------------------------------------------------------------------------
// rsw_pkg
// Shared types and constants for the record sorter (weight desc, name asc).
// ----------------------------------------------------------------------------
package rsw_pkg;

    localparam int WEIGHT_W      = 12;
    localparam int WORD_W        = 64;
    localparam int NAME_WORDS    = 7;
    localparam int NAME_BITS_MAX = WORD_W * NAME_WORDS;
    localparam int FIELDS_W      = WEIGHT_W + NAME_BITS_MAX;
    localparam int TDATA_W       = ((FIELDS_W + 7) / 8) * 8;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic unload;
    } t_cell_ctl;

    typedef struct packed {
        logic valid;
        logic ins;
    } t_link;

endpackage

FILE: hw/rtl/record_sort_weight_desc_name_asc_core.sv
// ----------------------------------------------------------------------------
// record_sort_weight_desc_name_asc_core
// Collects records into a sorted insertion chain, then streams them out by
// weight descending and name ascending, flagging dropped records.
// ----------------------------------------------------------------------------
// channel  dir  handshake               payload
// s        in   i_s_tvalid/o_s_tready   i_s_tdata (record), i_s_tlast (last of set)
// m        out  o_m_tvalid/i_m_tready   o_m_tdata (record), o_m_tlast, o_m_tuser (ovf)
//
// Load: one beat per cycle; each beat is sorted into the chain as it arrives
// (one key compare per cell sets the cycle).
// Emit: starts the cycle after the last beat, one beat per cycle, n beats.
// Input is held off (o_s_tready low) for the whole emit phase.
// Reset empties the chain and clears the overflow flag; no clearing pass.
// Stalls on the master side freeze the chain; cell 0 drives the output.
// ----------------------------------------------------------------------------
module record_sort_weight_desc_name_asc_core #(
    parameter int MAX_RECORDS = 64,
    parameter int NAME_BYTES  = 56
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // weight[11:0], name_word0..name_word6 (64 b each), zero pad to 464
    input  logic [rsw_pkg::TDATA_W-1:0]  i_s_tdata,
    input  logic                         i_s_tlast,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // out_weight[11:0], out_name0..out_name6 (64 b each), zero pad to 464
    output logic [rsw_pkg::TDATA_W-1:0]  o_m_tdata,
    output logic                         o_m_tlast,
    // overflowed
    output logic                         o_m_tuser
);

    localparam int NAME_W = NAME_BYTES * 8;
    localparam int KEY_W  = rsw_pkg::WEIGHT_W + NAME_W;
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);

    rsw_pkg::t_state   r_state;
    rsw_pkg::t_state   n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_ovf;
    logic              n_ovf;

    logic              w_s_beat;
    logic              w_m_beat;
    logic              w_full;
    rsw_pkg::t_cell_ctl w_ctl;

    logic [rsw_pkg::NAME_BITS_MAX-1:0] w_name_in;
    logic [rsw_pkg::NAME_BITS_MAX-1:0] w_name_out;
    logic [KEY_W-1:0]                  w_new_key;

    rsw_pkg::t_link    w_link [MAX_RECORDS];
    logic [KEY_W-1:0]  w_key  [MAX_RECORDS];

    assign w_s_beat = i_s_tvalid && o_s_tready;
    assign w_m_beat = o_m_tvalid && i_m_tready;
    assign w_full   = (r_count == CNT_W'(MAX_RECORDS));

    always_comb begin
        for (int k = 0; k < rsw_pkg::NAME_WORDS; k++) begin
            w_name_in[rsw_pkg::NAME_BITS_MAX-1-k*rsw_pkg::WORD_W -: rsw_pkg::WORD_W] =
                i_s_tdata[rsw_pkg::WEIGHT_W+k*rsw_pkg::WORD_W +: rsw_pkg::WORD_W];
        end
    end

    assign w_new_key = {i_s_tdata[rsw_pkg::WEIGHT_W-1:0],
                        w_name_in[rsw_pkg::NAME_BITS_MAX-1 -: NAME_W]};

    assign w_ctl.load   = w_s_beat && !w_full;
    assign w_ctl.unload = w_m_beat;

    for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
        rsw_pkg::t_link    w_prev;
        logic [KEY_W-1:0]  w_prev_key;
        logic              w_next_valid;
        logic [KEY_W-1:0]  w_next_key;

        if (g == 0) begin : g_head
            assign w_prev.valid = 1'b1;
            assign w_prev.ins   = 1'b0;
            assign w_prev_key   = w_new_key;
        end else begin : g_body
            assign w_prev     = w_link[g-1];
            assign w_prev_key = w_key[g-1];
        end

        if (g == MAX_RECORDS - 1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_key   = w_key[g];
        end else begin : g_mid
            assign w_next_valid = w_link[g+1].valid;
            assign w_next_key   = w_key[g+1];
        end

        rsw_cell #(
            .NAME_W (NAME_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_new_key    (w_new_key),
            .i_prev       (w_prev),
            .i_prev_key   (w_prev_key),
            .i_next_valid (w_next_valid),
            .i_next_key   (w_next_key),
            .o_link       (w_link[g]),
            .o_key        (w_key[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rsw_pkg::ST_LOAD: begin
                if (w_s_beat && i_s_tlast) begin
                    n_state = rsw_pkg::ST_EMIT;
                end
            end
            rsw_pkg::ST_EMIT: begin
                if (w_m_beat && (r_count == CNT_W'(1))) begin
                    n_state = rsw_pkg::ST_LOAD;
                end
            end
            default: n_state = rsw_pkg::ST_LOAD;
        endcase
    end

    // outputs and counters
    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        n_count    = r_count;
        n_ovf      = r_ovf;
        case (r_state)
            rsw_pkg::ST_LOAD: begin
                o_s_tready = 1'b1;
                if (w_s_beat) begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            rsw_pkg::ST_EMIT: begin
                o_m_tvalid = 1'b1;
                if (w_m_beat) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_ovf = 1'b0;
                    end
                end
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsw_pkg::ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    always_comb begin
        w_name_out = '0;
        w_name_out[rsw_pkg::NAME_BITS_MAX-1 -: NAME_W] = w_key[0][NAME_W-1:0];
        o_m_tdata = '0;
        o_m_tdata[rsw_pkg::WEIGHT_W-1:0] = w_key[0][KEY_W-1 -: rsw_pkg::WEIGHT_W];
        for (int k = 0; k < rsw_pkg::NAME_WORDS; k++) begin
            o_m_tdata[rsw_pkg::WEIGHT_W+k*rsw_pkg::WORD_W +: rsw_pkg::WORD_W] =
                w_name_out[rsw_pkg::NAME_BITS_MAX-1-k*rsw_pkg::WORD_W -: rsw_pkg::WORD_W];
        end
    end

    assign o_m_tlast = (r_count == CNT_W'(1));
    assign o_m_tuser = r_ovf;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("load and emit active together");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RECORDS))
        else $error("record count above capacity");

    a_emit_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_link[0].valid && (r_count != '0)))
        else $error("emit with empty chain head");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovf && (r_state == rsw_pkg::ST_LOAD)) |-> w_full)
        else $error("overflow flagged while not full");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_m_beat && o_m_tlast) |=> !w_link[0].valid)
        else $error("chain not empty after last beat");

endmodule

FILE: hw/rtl/rsw_cell.sv
// ----------------------------------------------------------------------------
// rsw_cell
// One slot of the insertion chain: holds one record, compares it with the
// incoming record, and shifts toward the tail on insert or the head on unload.
// ----------------------------------------------------------------------------
module rsw_cell #(
    parameter int NAME_W = 448
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  rsw_pkg::t_cell_ctl                     i_ctl,
    input  logic [rsw_pkg::WEIGHT_W+NAME_W-1:0]    i_new_key,
    input  rsw_pkg::t_link                         i_prev,
    input  logic [rsw_pkg::WEIGHT_W+NAME_W-1:0]    i_prev_key,
    input  logic                                   i_next_valid,
    input  logic [rsw_pkg::WEIGHT_W+NAME_W-1:0]    i_next_key,
    output rsw_pkg::t_link                         o_link,
    output logic [rsw_pkg::WEIGHT_W+NAME_W-1:0]    o_key
);

    localparam int KEY_W = rsw_pkg::WEIGHT_W + NAME_W;

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic             n_valid;
    logic [KEY_W-1:0] n_key;
    logic [KEY_W-1:0] w_rank_new;
    logic [KEY_W-1:0] w_rank_own;
    logic             w_ins;

    // larger weight first, then smaller name: invert the name bits
    assign w_rank_new = {i_new_key[KEY_W-1 -: rsw_pkg::WEIGHT_W], ~i_new_key[NAME_W-1:0]};
    assign w_rank_own = {r_key[KEY_W-1 -: rsw_pkg::WEIGHT_W], ~r_key[NAME_W-1:0]};
    // an empty cell only fills when the cell ahead of it holds a record
    assign w_ins      = i_ctl.load && (r_valid ? (w_rank_new > w_rank_own) : i_prev.valid);

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        if (i_ctl.load && w_ins) begin
            n_valid = 1'b1;
            n_key   = i_prev.ins ? i_prev_key : i_new_key;
        end else if (i_ctl.unload) begin
            n_valid = i_next_valid;
            n_key   = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_link.valid = r_valid;
    assign o_link.ins   = w_ins;
    assign o_key        = r_key;

endmodule

FILE: bench/record_sort_weight_desc_name_asc_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_sort_weight_desc_name_asc_core_tb
// Streams sets of records into the sorter and checks every output beat
// against a behavioral sort: weight descending, names ascending word by word,
// tlast on the final beat of a set and tuser flagging dropped records.
// ----------------------------------------------------------------------------
module record_sort_weight_desc_name_asc_core_tb;

    localparam int MAX_REC      = 64;
    localparam int NAME_BYTES   = 56;
    localparam int CLK_HALF     = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int ITEM_TARGET  = 470;
    localparam int REPORT_LIMIT = 10;

    typedef logic [rsw_pkg::WORD_W-1:0]   t_word;
    typedef logic [rsw_pkg::WEIGHT_W-1:0] t_weight;

    typedef struct packed {
        t_weight                                 weight;
        logic [rsw_pkg::NAME_WORDS-1:0][rsw_pkg::WORD_W-1:0] name;
    } t_rec;

    typedef struct packed {
        t_rec rec;
        logic last;
        logic ovf;
    } t_sorted_beat;

    class record_sort_scoreboard;
        t_rec         set_q[$];
        bit           dropped;
        t_sorted_beat order_q[$];
        int           failures;

        function new();
            dropped  = 0;
            failures = 0;
        endfunction

        function t_word trim_word(int k, t_word w);
            int first;
            int keep;
            first = k * 8;
            if (first >= NAME_BYTES) return '0;
            keep = NAME_BYTES - first;
            if (keep >= 8) return w;
            return w & ~({rsw_pkg::WORD_W{1'b1}} >> (keep * 8));
        endfunction

        function bit outranks(t_rec a, t_rec b);
            if (a.weight != b.weight) return a.weight > b.weight;
            for (int k = 0; k < rsw_pkg::NAME_WORDS; k++) begin
                if (a.name[k] != b.name[k]) return a.name[k] < b.name[k];
            end
            return 0;
        endfunction

        function void note_record(t_rec r, bit last);
            t_rec         t;
            t_sorted_beat b;
            int           best;
            t = r;
            for (int k = 0; k < rsw_pkg::NAME_WORDS; k++) t.name[k] = trim_word(k, r.name[k]);
            if (set_q.size() < MAX_REC) set_q.push_back(t);
            else dropped = 1;
            if (!last) return;
            for (int i = 0; i < set_q.size(); i++) begin
                best = i;
                for (int j = i + 1; j < set_q.size(); j++) begin
                    if (outranks(set_q[j], set_q[best])) best = j;
                end
                if (best != i) begin
                    t           = set_q[i];
                    set_q[i]    = set_q[best];
                    set_q[best] = t;
                end
            end
            for (int i = 0; i < set_q.size(); i++) begin
                b.rec  = set_q[i];
                b.last = (i == set_q.size() - 1);
                b.ovf  = dropped;
                order_q.push_back(b);
            end
            set_q.delete();
            dropped = 0;
        endfunction

        function int pending();
            return order_q.size();
        endfunction

        function void report(string what, t_word exp_v, t_word act_v);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%0t: bad %s: expected %h, got %h", $realtime, what, exp_v, act_v);
        endfunction

        function void check_beat(logic [rsw_pkg::TDATA_W-1:0] td, logic tl, logic tu);
            t_sorted_beat e;
            if (order_q.size() == 0) begin
                report("beat, none expected, weight", '0, t_word'(td[rsw_pkg::WEIGHT_W-1:0]));
                return;
            end
            e = order_q.pop_front();
            if (td[rsw_pkg::WEIGHT_W-1:0] !== e.rec.weight)
                report("weight", t_word'(e.rec.weight), t_word'(td[rsw_pkg::WEIGHT_W-1:0]));
            for (int k = 0; k < rsw_pkg::NAME_WORDS; k++) begin
                if (td[rsw_pkg::WEIGHT_W + rsw_pkg::WORD_W*k +: rsw_pkg::WORD_W] !== e.rec.name[k])
                    report($sformatf("name word %0d", k), e.rec.name[k],
                           td[rsw_pkg::WEIGHT_W + rsw_pkg::WORD_W*k +: rsw_pkg::WORD_W]);
            end
            if (tl !== e.last) report("tlast", t_word'(e.last), t_word'(tl));
            if (tu !== e.ovf) report("overflow flag", t_word'(e.ovf), t_word'(tu));
        endfunction

        function void check_drained();
            t_sorted_beat e;
            while (order_q.size() != 0) begin
                e = order_q.pop_front();
                report("beat never arrived, weight", t_word'(e.rec.weight), '0);
            end
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [rsw_pkg::TDATA_W-1:0]  s_tdata;   // weight[11:0], name_word0..6, zero pad
    logic                         s_tlast;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [rsw_pkg::TDATA_W-1:0]  m_tdata;   // out_weight[11:0], out_name0..6, zero pad
    logic                         m_tlast;
    logic                         m_tuser;   // overflowed

    record_sort_scoreboard sb;
    int                    items_sent;
    bit                    idle_free;

    record_sort_weight_desc_name_asc_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (idle_free) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_word rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic t_rec mk_rec(t_weight w, t_word fill, int word_idx, t_word val);
        t_rec r;
        r.weight = w;
        for (int k = 0; k < rsw_pkg::NAME_WORDS; k++) r.name[k] = fill;
        r.name[word_idx] = val;
        return r;
    endfunction

    task automatic send_record(t_rec r, bit last);
        int                          gap;
        logic [rsw_pkg::TDATA_W-1:0] td;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        td = '0;
        td[rsw_pkg::WEIGHT_W-1:0] = r.weight;
        for (int k = 0; k < rsw_pkg::NAME_WORDS; k++)
            td[rsw_pkg::WEIGHT_W + rsw_pkg::WORD_W*k +: rsw_pkg::WORD_W] = r.name[k];
        s_tdata  <= td;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        sb.note_record(r, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    // names drawn from a per-set base so ties reach deep into the words
    task automatic run_set(int n);
        t_rec base;
        t_rec r;
        int   pick;
        base.weight = t_weight'($urandom);
        for (int k = 0; k < rsw_pkg::NAME_WORDS; k++) base.name[k] = rand_word();
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) r.weight = t_weight'($urandom_range(0, 3) + base.weight);
            else if (pick < 70) r.weight = ($urandom_range(0, 1) != 0) ? '1 : '0;
            else r.weight = t_weight'($urandom);
            for (int k = 0; k < rsw_pkg::NAME_WORDS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) r.name[k] = base.name[k];
                else if (pick < 60) r.name[k] = '0;
                else if (pick < 70) r.name[k] = '1;
                else r.name[k] = rand_word();
            end
            send_record(r, i == n - 1);
        end
    endtask

    initial begin
        forever begin
            repeat ($urandom_range(150, 400)) @(posedge i_clk);
            idle_free = !idle_free;
        end
    end

    // sink: random stalls plus one long hold-off while a big set is emitting
    initial begin
        int stall_left;
        int hold_left;
        bit hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && m_tvalid && sb.pending() > 20) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = pick_gap();
                if (stall_left > 0) begin
                    m_tready <= 1'b0;
                    stall_left--;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast, m_tuser);
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int set_no;
        int sz;
        int guard;
        int r;
        s_tvalid   = 1'b0;
        s_tlast    = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        i_rst_n    = 1'b0;
        items_sent = 0;
        idle_free  = 0;
        sb         = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single-record set
        send_record(mk_rec('1, '1, 0, '1), 1);
        // extremes, deep ties, unsigned order, bytes after a zero byte, duplicates
        send_record(mk_rec('0, '0, 0, '0), 0);
        send_record(mk_rec('1, '0, 0, '0), 0);
        send_record(mk_rec('1, '1, 0, '1), 0);
        send_record(mk_rec(12'h800, '0, 6, 64'h1), 0);
        send_record(mk_rec(12'h800, '0, 6, 64'h0), 0);
        send_record(mk_rec(12'h800, '0, 0, 64'h8000_0000_0000_0000), 0);
        send_record(mk_rec(12'h800, '0, 0, 64'h7FFF_FFFF_FFFF_FFFF), 0);
        send_record(mk_rec(12'h7FF, '0, 0, 64'h4100_0000_0000_005A), 0);
        send_record(mk_rec(12'h7FF, '0, 0, 64'h4100_0000_0000_0000), 0);
        send_record(mk_rec(12'h7FF, '0, 0, 64'h4100_0000_0000_0000), 0);
        send_record(mk_rec(12'h555, '1, 3, '0), 0);
        send_record(mk_rec(12'hAAA, 64'hA5A5_A5A5_A5A5_A5A5, 5, 64'h5A5A_5A5A_5A5A_5A5A), 1);
        send_record(mk_rec(12'h123, 64'h6162_6300_0000_0000, 1, 64'hFF00_0000_0000_0000), 0);
        send_record(mk_rec(12'h123, 64'h6162_6300_0000_0000, 1, 64'h00FF_0000_0000_0000), 1);
        wait_drained();

        // store overflow with the last three beats dropped, then a full store
        run_set(67);
        run_set(MAX_REC);
        set_no = 0;
        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 50) sz = $urandom_range(1, 8);
            else if (r < 80) sz = $urandom_range(9, 24);
            else if (r < 92) sz = $urandom_range(25, MAX_REC);
            else sz = $urandom_range(MAX_REC + 1, MAX_REC + 8);
            if (set_no == 5) wait_drained();
            run_set(sz);
            set_no++;
        end
        s_tvalid <= 1'b0;

        guard = 0;
        while (sb.pending() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        sb.check_drained();
        if (sb.failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
